// File: src/oaht_pkg.sv
// Package: shared constants and types for the hash table, including the FNV hash constants
`timescale 1ns / 1ps
package oaht_pkg;
    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = IDX_W + 1;
    localparam int BYTE_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    localparam logic [63:0] FNV_OFFSET = 64'd14695981039346656037;
    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam logic [7:0]  META_EMPTY   = 8'h80;
    localparam logic [7:0]  META_DELETED = 8'hfe;
    localparam logic [6:0]  TAG_MASK     = 7'h7f;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_UNSET = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [63:0] value;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [63:0] read_value;
        logic        status;
        logic [6:0]  entries;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [63:0] key;
    } hash_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] hash;
    } hash_rsp_t;
endpackage

// File: src/oaht_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: src/oaht_hash.sv
// FNV-1a hash unit: one byte per round through a shared multiplier split in halves
`timescale 1ns / 1ps
module oaht_hash
    import oaht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hash_cmd_t cmd,
    output hash_rsp_t rsp
);
    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_XOR  = 4'b0010,
        H_LO   = 4'b0100,
        H_HI   = 4'b1000
    } hstate_t;

    hstate_t      state_reg, state_next;
    logic [63:0]  h_reg, h_next;
    logic [63:0]  key_reg, key_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [63:0]  lo_reg, lo_next;
    logic [31:0]  mul_a;
    logic [63:0]  mul_p;
    logic         last;
    logic         done_reg;

    // prime = 2^40 + 0x1b3: h*prime = (h<<40) + h*0x1b3, split the narrow product
    assign mul_a = (state_reg == H_LO) ? h_reg[31:0] : h_reg[63:32];
    assign mul_p = {32'd0, mul_a} * {55'd0, FNV_PRIME[8:0]};
    assign last  = (byte_reg == BYTE_W'(KEY_BYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        key_next   = key_reg;
        byte_next  = byte_reg;
        lo_next    = lo_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    h_next     = FNV_OFFSET;
                    key_next   = cmd.key;
                    byte_next  = '0;
                    state_next = H_XOR;
                end
            end
            H_XOR:
            begin
                h_next     = h_reg ^ {56'd0, key_reg[7:0]};
                key_next   = key_reg >> 8;
                state_next = H_LO;
            end
            H_LO:
            begin
                lo_next    = mul_p;
                state_next = H_HI;
            end
            H_HI:
            begin
                h_next = (h_reg << 40) + lo_reg + {mul_p[31:0], 32'd0};
                if (last)
                begin
                    state_next = H_IDLE;
                end
                else
                begin
                    byte_next  = byte_reg + 1'b1;
                    state_next = H_XOR;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            byte_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            byte_reg  <= byte_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        key_reg <= key_next;
        lo_reg  <= lo_next;
    end

    // done pulses the cycle after the final round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == H_HI) && last;
        end
    end
    assign rsp.done = done_reg;
    assign rsp.hash = h_reg;
endmodule

// File: src/open_addressing_hash_table.sv
// Top level: hash table sequencer, slot stores and result register
//
//   channel | handshake        | payload
//   req     | start / busy     | req    (op, key, value)
//   rsp     | done strobe      | rsp    (found, read_value, status, entries)
//   cfg     | cfg_valid/ready  | cfg_data (fill limit)
//
// A request is accepted, then hashed one key byte per round (xor, low and high
// multiply halves); each probe step reads then checks a slot; a write (a get
// adds a read) precedes done, as the FNV rounds and single-port slot stores need.
// Clear sweeps all slots, one per cycle; after reset the same sweep runs before
// start is taken. busy stays high throughout.
// The result is on rsp in the cycle that done is high and holds until a later request updates it.
`timescale 1ns / 1ps
module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data
);
    typedef enum logic [6:0] {
        S_SWEEP = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_READ  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_ACT   = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    req_t           req_reg, req_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] load_reg, load_next;
    logic [5:0]     fill_limit_reg;
    logic [6:0]     tag_reg, tag_next;
    logic           hit_reg, hit_next;
    logic           empty_reg, empty_next;
    logic           done_reg, done_next;
    rsp_t           rsp_reg, rsp_next;
    hash_cmd_t      hcmd;
    hash_rsp_t      hrsp;

    logic              meta_we, key_we, val_we;
    logic [7:0]        meta_wd, meta_rd;
    logic [63:0]       key_rd, val_rd;
    logic              refuse;

    oaht_hash u_hash (.clk(clk), .rst_n(rst_n), .cmd(hcmd), .rsp(hrsp));

    oaht_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_meta (
        .clk(clk), .we(meta_we), .addr(idx_reg), .wdata(meta_wd), .rdata(meta_rd));
    oaht_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(key_we), .addr(idx_reg), .wdata(req_reg.key), .rdata(key_rd));
    oaht_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(val_we), .addr(idx_reg), .wdata(req_reg.value), .rdata(val_rd));

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign hcmd.start = (state_reg == S_IDLE) && start && (req.op != OP_CLEAR);
    assign hcmd.key   = req.key;

    assign refuse = !empty_reg || (load_reg > {1'b0, fill_limit_reg})
                    || (load_reg >= CNT_W'(CAPACITY - 1));

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        live_next  = live_reg;
        load_next  = load_reg;
        tag_next   = tag_reg;
        hit_next   = hit_reg;
        empty_next = empty_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        meta_we    = 1'b0;
        key_we     = 1'b0;
        val_we     = 1'b0;
        meta_wd    = META_EMPTY;
        unique case (state_reg)
            S_SWEEP:
            begin
                meta_we  = 1'b1;
                meta_wd  = META_EMPTY;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                    if (req_reg.op == OP_CLEAR)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '0;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (req.op == OP_CLEAR)
                    begin
                        idx_next   = '0;
                        live_next  = '0;
                        load_next  = '0;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hrsp.done)
                begin
                    idx_next   = hrsp.hash[7 +: IDX_W];
                    tag_next   = hrsp.hash[6:0] & TAG_MASK;
                    step_next  = '0;
                    hit_next   = 1'b0;
                    empty_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!meta_rd[7] && meta_rd[6:0] == tag_reg && key_rd == req_reg.key)
                begin
                    hit_next   = 1'b1;
                    state_next = S_ACT;
                end
                else if (meta_rd[7] && meta_rd != META_DELETED)
                begin
                    empty_next = 1'b1;
                    state_next = S_ACT;
                end
                else if (step_reg == CNT_W'(CAPACITY - 1))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ACT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    step_next  = step_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_ACT:
            begin
                rsp_next.found      = hit_reg;
                rsp_next.read_value = '0;
                rsp_next.status     = 1'b0;
                priority case (req_reg.op)
                    OP_GET:
                    begin
                        state_next = S_WAIT;
                    end
                    OP_SET:
                    begin
                        if (hit_reg)
                        begin
                            val_we = 1'b1;
                        end
                        else if (refuse)
                        begin
                            rsp_next.status = 1'b1;
                        end
                        else
                        begin
                            meta_we   = 1'b1;
                            meta_wd   = {1'b0, tag_reg};
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            live_next = live_reg + 1'b1;
                            load_next = load_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            meta_we = 1'b1;
                            meta_wd = META_DELETED;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                        end
                    end
                endcase
                rsp_next.entries = 7'(live_next);
                if (req_reg.op != OP_GET)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                if (hit_reg)
                begin
                    rsp_next.read_value = val_rd;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            req_reg        <= '0;
            idx_reg        <= '0;
            step_reg       <= '0;
            live_reg       <= '0;
            load_reg       <= '0;
            fill_limit_reg <= 6'd32;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            empty_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            live_reg  <= live_next;
            load_reg  <= load_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            empty_reg <= empty_next;
            if (cfg_valid && cfg_ready)
            begin
                fill_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        rsp_reg <= rsp_next;
    end
endmodule

// File: test/testbench.sv
// Testbench for the open addressing hash table: predicted results against observed ones
`timescale 1ns / 1ps
module testbench;
    import oaht_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [5:0] cfg_data;

    open_addressing_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    logic [7:0]  tbl_meta [CAPACITY];
    logic [63:0] tbl_key  [CAPACITY];
    logic [63:0] tbl_val  [CAPACITY];
    int unsigned live_keys;
    int unsigned used_slots;
    int unsigned load_limit = 32;

    req_t        pending_words [$];
    rsp_t        expected_rsp  [$];
    logic [63:0] key_pool      [$];
    int          mismatch_count = 0;
    int          idle_pct;
    int          idle_cycles;
    bit          timed_out;
    int          cfg_requests = 0;
    int          cfg_writes   = 0;
    logic [5:0]  cfg_word;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] fnv1a(input logic [63:0] k);
        logic [63:0] h;
        h = FNV_OFFSET;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            h = h ^ {56'd0, k[8*i +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic void table_empty();
        for (int i = 0; i < CAPACITY; i++)
            tbl_meta[i] = META_EMPTY;
        live_keys  = 0;
        used_slots = 0;
    endfunction

    function automatic rsp_t table_apply(input req_t w);
        rsp_t        r;
        logic [63:0] h;
        logic [7:0]  tag;
        int          idx;
        bit          hit;
        bit          empty_end;
        r   = '0;
        hit = 0;
        empty_end = 0;
        if (w.op == OP_CLEAR)
            table_empty();
        else
        begin
            h   = fnv1a(w.key);
            tag = {1'b0, h[6:0]};
            idx = int'(h[12:7]);
            for (int n = 0; n < CAPACITY; n++)
            begin
                if (!tbl_meta[idx][7])
                begin
                    if (tbl_meta[idx] == tag && tbl_key[idx] == w.key)
                    begin
                        hit = 1;
                        break;
                    end
                end
                else if (tbl_meta[idx] != META_DELETED)
                begin
                    empty_end = 1;
                    break;
                end
                idx = (idx + 1) % CAPACITY;
            end
            r.found = hit;
            if (w.op == OP_GET)
            begin
                if (hit)
                    r.read_value = tbl_val[idx];
            end
            else if (w.op == OP_SET)
            begin
                if (hit)
                    tbl_val[idx] = w.value;
                else if (!empty_end || used_slots > load_limit
                         || used_slots + 1 >= CAPACITY)
                    r.status = 1'b1;
                else
                begin
                    tbl_meta[idx] = tag;
                    tbl_key[idx]  = w.key;
                    tbl_val[idx]  = w.value;
                    live_keys++;
                    used_slots++;
                end
            end
            else if (hit)
            begin
                tbl_meta[idx] = META_DELETED;
                if (live_keys > 0)
                    live_keys--;
            end
        end
        r.entries = live_keys[6:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (key_pool.size() == 0 || $urandom_range(0, 3) == 0)
        begin
            key_pool.push_back(rand64());
            if (key_pool.size() > 90)
                void'(key_pool.pop_front());
            return key_pool[key_pool.size() - 1];
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic void queue_word(input logic [1:0] op, input logic [63:0] k,
                                       input logic [63:0] v);
        req_t w;
        w.op    = op;
        w.key   = k;
        w.value = v;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_random(input int count);
        int          sel;
        logic [1:0]  op;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                op = OP_SET;
            else if (sel < 75)
                op = OP_GET;
            else if (sel < 97)
                op = OP_UNSET;
            else
                op = OP_CLEAR;
            queue_word(op, pick_key(), rand64());
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
            table_empty();
        end
        else
        begin
            if (start && !busy)
            begin
                expected_rsp.push_back(table_apply(req));
                void'(pending_words.pop_front());
                if (pending_words.size() == 0 || $urandom_range(0, 99) < idle_pct)
                    start <= 1'b0;
                else
                    req <= pending_words[0];
            end
            else if (!start && pending_words.size() > 0
                     && $urandom_range(0, 99) >= idle_pct)
            begin
                start <= 1'b1;
                req   <= pending_words[0];
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid  <= 1'b0;
            load_limit = int'(cfg_data);
            cfg_writes++;
        end
        else if (cfg_requests != cfg_writes && !cfg_valid)
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_word;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsp.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: %p", rsp);
            end
            else if (rsp !== expected_rsp[0])
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: expected %p, got %p", expected_rsp[0], rsp);
                void'(expected_rsp.pop_front());
            end
            else
                void'(expected_rsp.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
            timed_out = 1;
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || start || expected_rsp.size() > 0)
        begin
            @(posedge clk);
            if (timed_out)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [5:0] lim);
        wait_drained();
        cfg_word = lim;
        cfg_requests++;
        while (cfg_requests != cfg_writes)
        begin
            @(posedge clk);
            if (timed_out)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    endtask

    task automatic run_phase(input int pct, input int count);
        idle_pct = pct;
        queue_random(count);
        wait_drained();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(OP_GET, 64'd0, 64'd0);
        queue_word(OP_SET, 64'd0, 64'hffff_ffff_ffff_ffff);
        queue_word(OP_GET, 64'd0, 64'd0);
        queue_word(OP_SET, 64'hffff_ffff_ffff_ffff, 64'd0);
        queue_word(OP_SET, 64'hffff_ffff_ffff_ffff, 64'h5555_aaaa_5555_aaaa);
        queue_word(OP_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
        queue_word(OP_UNSET, 64'd0, 64'd0);
        queue_word(OP_UNSET, 64'd0, 64'd0);
        queue_word(OP_GET, 64'd0, 64'd0);
        queue_word(OP_SET, 64'd0, 64'haaaa_5555_aaaa_5555);
        queue_word(OP_GET, 64'd0, 64'd0);
        queue_word(OP_CLEAR, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        queue_word(OP_GET, 64'hffff_ffff_ffff_ffff, 64'd0);
        wait_drained();

        write_limit(6'd0);
        for (int i = 0; i < 4; i++)
            queue_word(OP_SET, 64'h100 + i, 64'h200 + i);
        queue_word(OP_SET, 64'h100, 64'h777);
        queue_word(OP_UNSET, 64'h101, 64'd0);
        queue_word(OP_SET, 64'h105, 64'd1);
        queue_word(OP_CLEAR, 64'd0, 64'd0);
        wait_drained();

        write_limit(6'd63);
        for (int i = 0; i < 66; i++)
            queue_word(OP_SET, rand64(), rand64());
        queue_word(OP_GET, 64'd0, 64'd0);
        run_phase(0, 200);

        write_limit(6'd32);
        run_phase(60, 300);
        write_limit(6'd10);
        run_phase(0, 300);
        write_limit(6'd63);
        run_phase(60, 200);
        queue_word(OP_CLEAR, 64'd0, 64'd0);
        run_phase(31, 250);
        write_limit(6'($urandom_range(0, 63)));
        run_phase(0, 250);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
